// ===== rtl/core/iss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store package
// Shared constants, operation and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package iss_pkg;

   // Default sizing of the store.
   localparam int DEPTH_DEFAULT       = 64;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Fixed widths of the stream fields.
   localparam int OP_WIDTH        = 3;
   localparam int POS_WIDTH       = 7;
   localparam int DATA_WIDTH      = 32;
   localparam int COUNT_WIDTH     = 7;
   localparam int STATUS_WIDTH    = 2;
   localparam int REQ_TDATA_WIDTH = 40;
   localparam int RSP_TDATA_WIDTH = 40;

   // Operation codes carried on the request tuser.
   typedef enum logic [OP_WIDTH-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_INSERT     = 3'd2,
      OP_REMOVE     = 3'd3,
      OP_POP_FRONT  = 3'd4,
      OP_POP_BACK   = 3'd5,
      OP_READ       = 3'd6,
      OP_CLEAR      = 3'd7
   } iss_op_type;

   // Status codes carried on the response tuser.
   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } iss_status_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic ins;   // open a slot at the selected index and write the new word
      logic rem;   // close the slot at the selected index
      logic rd;    // drive the selected word onto the read tap
   } iss_cell_ctl_type;

endpackage

// ===== rtl/core/indexed_sequence_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store
// Bounded ordered list of signed words with indexed insert, remove and read.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfer on the req_ channel carries one operation in req_tuser
//   and its position and value in req_tdata. Every request yields exactly one
//   response transfer on the rsp_ channel with the value read or removed, the
//   element count after the operation and a status code.
//   The elements live in a row of DEPTH cells. Insert and remove shift every
//   cell at or past the index by one place toward its neighbor, so each
//   operation completes in the cycle it is accepted. The response is
//   registered, so response valid rises in the cycle after the request
//   transfer, and one request per cycle is taken as long as the response is
//   consumed. The response sits in an output register: a new request is
//   accepted in the same cycle that the waiting response is taken.
//   When the receiver stalls, the response holds and req_tready drops until
//   the response is taken. Full, empty and out-of-range cases return a status
//   with a zero value and leave the list unchanged.
//   Reset empties the list and drops any pending response; no clearing pass
//   is needed since only written cells are ever read.
// ----------------------------------------------------------------------------
module indexed_sequence_store #(
   parameter int DEPTH       = iss_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = iss_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request channel.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // req_tdata: position [6:0], value [38:7], zero pad [39]
   input  logic [iss_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   // req_tuser: operation [2:0]
   input  logic [iss_pkg::OP_WIDTH-1:0]          req_tuser,
   // Response channel.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // rsp_tdata: read_value [31:0], count [38:32], zero pad [39]
   output logic [iss_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   // rsp_tuser: status [1:0]
   output logic [iss_pkg::STATUS_WIDTH-1:0]      rsp_tuser
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic                                 accept;
   logic [iss_pkg::POS_WIDTH-1:0]        req_pos;
   logic signed [iss_pkg::DATA_WIDTH-1:0] req_value;
   logic [VALUE_WIDTH-1:0]               new_word;
   iss_pkg::iss_cell_ctl_type            ctl;
   logic [IW-1:0]                        sel_pos;
   iss_pkg::iss_status_type              status;
   logic [CW-1:0]                        count_next;
   logic [VALUE_WIDTH-1:0]               cell_word [DEPTH];
   logic [VALUE_WIDTH-1:0]               cell_tap  [DEPTH];
   logic [VALUE_WIDTH-1:0]               left_nbr  [DEPTH];
   logic [VALUE_WIDTH-1:0]               right_nbr [DEPTH];
   logic signed [VALUE_WIDTH-1:0]        rd_word;
   logic signed [iss_pkg::DATA_WIDTH-1:0] rd_value;

   logic                                 rsp_valid_ff;
   logic                                 rsp_valid_in;
   logic [iss_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata_ff;
   logic [iss_pkg::STATUS_WIDTH-1:0]     rsp_tuser_ff;

   // Request transfer and field unpacking.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign req_pos    = req_tdata[6:0];
   assign req_value  = req_tdata[38:7];
   assign new_word   = VALUE_WIDTH'(req_value);

   // Operation decode and element count.
   iss_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .op         (iss_pkg::iss_op_type'(req_tuser)),
      .pos        (req_pos),
      .ctl        (ctl),
      .sel_pos    (sel_pos),
      .status     (status),
      .count_next (count_next)
   );

   // Row of element cells, each wired to its two neighbors.
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
         assign left_nbr[g] = new_word;
      end else begin : g_inner_l
         assign left_nbr[g] = cell_word[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign right_nbr[g] = cell_word[g];
      end else begin : g_inner_r
         assign right_nbr[g] = cell_word[g+1];
      end

      iss_cell #(
         .DEPTH       (DEPTH),
         .VALUE_WIDTH (VALUE_WIDTH),
         .INDEX       (g)
      ) u_cell (
         .clock      (clock),
         .accept     (accept),
         .ctl        (ctl),
         .sel_pos    (sel_pos),
         .new_word   (new_word),
         .left_word  (left_nbr[g]),
         .right_word (right_nbr[g]),
         .word_out   (cell_word[g]),
         .tap        (cell_tap[g])
      );
   end

   // Combine the read taps; at most one cell drives a nonzero word.
   always_comb begin
      rd_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         rd_word = rd_word | cell_tap[i];
      end
   end

   assign rd_value = iss_pkg::DATA_WIDTH'(rd_word);

   // Response register, loaded on every request transfer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_tdata_ff <= {1'b0, iss_pkg::COUNT_WIDTH'(count_next), rd_value};
         rsp_tuser_ff <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

// ===== rtl/core/iss_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store cell
// Holds one element and trades it with its neighbors on insert and remove.
// ----------------------------------------------------------------------------
module iss_cell #(
   parameter int DEPTH       = iss_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = iss_pkg::VALUE_WIDTH_DEFAULT,
   parameter int INDEX       = 0
) (
   input  logic                          clock,
   input  logic                          accept,
   input  iss_pkg::iss_cell_ctl_type     ctl,
   input  logic [$clog2(DEPTH)-1:0]      sel_pos,
   input  logic [VALUE_WIDTH-1:0]        new_word,
   input  logic [VALUE_WIDTH-1:0]        left_word,
   input  logic [VALUE_WIDTH-1:0]        right_word,
   output logic [VALUE_WIDTH-1:0]        word_out,
   output logic [VALUE_WIDTH-1:0]        tap
);

   localparam int IW = $clog2(DEPTH);
   localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

   logic [VALUE_WIDTH-1:0] entry_ff;
   logic [VALUE_WIDTH-1:0] entry_in;

   // Pick the next content: shift toward the back on insert, toward the front
   // on remove, otherwise hold.
   always_comb begin
      entry_in = entry_ff;
      if (accept && ctl.ins) begin
         if (MY_IDX > sel_pos) begin
            entry_in = left_word;
         end else if (MY_IDX == sel_pos) begin
            entry_in = new_word;
         end
      end else if (accept && ctl.rem) begin
         if (MY_IDX >= sel_pos) begin
            entry_in = right_word;
         end
      end
   end

   // Element storage; its contents are meaningless until written.
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign word_out = entry_ff;

   // Only the selected cell puts its word on the shared read tap.
   assign tap = (ctl.rd && (MY_IDX == sel_pos)) ? entry_ff : '0;

endmodule

// ===== rtl/core/iss_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store controller
// Decodes operations, checks fullness, emptiness and range, and keeps the element count.
// ----------------------------------------------------------------------------
module iss_ctrl #(
   parameter int DEPTH = iss_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  iss_pkg::iss_op_type               op,
   input  logic [iss_pkg::POS_WIDTH-1:0]     pos,
   output iss_pkg::iss_cell_ctl_type         ctl,
   output logic [$clog2(DEPTH)-1:0]          sel_pos,
   output iss_pkg::iss_status_type           status,
   output logic [$clog2(DEPTH+1)-1:0]        count_next
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > iss_pkg::POS_WIDTH) ? CW : iss_pkg::POS_WIDTH;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] count_m1;
   logic [CW-1:0] count_p1;
   logic [XW-1:0] pos_x;
   logic [XW-1:0] cnt_x;
   logic          full;
   logic          empty;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count_m1 = count_ff - CW'(1);
   assign count_p1 = count_ff + CW'(1);
   assign pos_x    = XW'(pos);
   assign cnt_x    = XW'(count_ff);

   // Operation decode. A rejected operation leaves the store untouched.
   always_comb begin
      ctl      = '0;
      sel_pos  = '0;
      status   = iss_pkg::ST_OK;
      count_in = count_ff;
      unique case (op)
         iss_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               status = iss_pkg::ST_FULL;
            end else begin
               ctl.ins  = 1'b1;
               count_in = count_p1;
            end
         end
         iss_pkg::OP_PUSH_BACK: begin
            if (full) begin
               status = iss_pkg::ST_FULL;
            end else begin
               ctl.ins  = 1'b1;
               sel_pos  = count_ff[IW-1:0];
               count_in = count_p1;
            end
         end
         iss_pkg::OP_INSERT: begin
            if (full) begin
               status = iss_pkg::ST_FULL;
            end else if (pos_x > cnt_x) begin
               status = iss_pkg::ST_RANGE;
            end else begin
               ctl.ins  = 1'b1;
               sel_pos  = pos_x[IW-1:0];
               count_in = count_p1;
            end
         end
         iss_pkg::OP_REMOVE: begin
            if (empty) begin
               status = iss_pkg::ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
               status = iss_pkg::ST_RANGE;
            end else begin
               ctl.rem  = 1'b1;
               ctl.rd   = 1'b1;
               sel_pos  = pos_x[IW-1:0];
               count_in = count_m1;
            end
         end
         iss_pkg::OP_POP_FRONT: begin
            if (empty) begin
               status = iss_pkg::ST_EMPTY;
            end else begin
               ctl.rem  = 1'b1;
               ctl.rd   = 1'b1;
               count_in = count_m1;
            end
         end
         iss_pkg::OP_POP_BACK: begin
            if (empty) begin
               status = iss_pkg::ST_EMPTY;
            end else begin
               ctl.rem  = 1'b1;
               ctl.rd   = 1'b1;
               sel_pos  = count_m1[IW-1:0];
               count_in = count_m1;
            end
         end
         iss_pkg::OP_READ: begin
            if (empty) begin
               status = iss_pkg::ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
               status = iss_pkg::ST_RANGE;
            end else begin
               ctl.rd  = 1'b1;
               sel_pos = pos_x[IW-1:0];
            end
         end
         iss_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Element count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   assign count_next = count_in;

endmodule

// ===== rtl/core/iss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store checker
// Port-level properties of the store, bound to the top level.
// ----------------------------------------------------------------------------
module iss_port_checker #(
   parameter int DEPTH = iss_pkg::DEPTH_DEFAULT
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic [iss_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   input logic [iss_pkg::OP_WIDTH-1:0]          req_tuser,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [iss_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata,
   input logic [iss_pkg::STATUS_WIDTH-1:0]      rsp_tuser
);

   // A stalled response stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response withdrawn while stalled");

   // A rejected operation reports a zero value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != iss_pkg::ST_OK) |-> (rsp_tdata[31:0] == '0))
      else $error("nonzero value on a rejected operation");

   // A full report means the count sits at the capacity.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == iss_pkg::ST_FULL)
      |-> (rsp_tdata[38:32] == iss_pkg::COUNT_WIDTH'(DEPTH)))
      else $error("full status with count below capacity");

   // A clear transfer is answered in the next cycle with an empty, good result.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == iss_pkg::OP_CLEAR)
      |=> rsp_tvalid && (rsp_tdata[38:32] == '0) && (rsp_tuser == iss_pkg::ST_OK))
      else $error("clear not answered with an empty list");

   // The reported count never exceeds the capacity.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(rsp_tdata[38:32]) <= DEPTH))
      else $error("count above capacity");

endmodule

bind indexed_sequence_store iss_port_checker #(.DEPTH(DEPTH)) u_iss_checker (.*);

// ===== dv/iss_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store checker
// Watches the request and response channels, keeps its own copy of the list,
// predicts one response per request and compares every response field by
// field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module iss_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   // req_tdata: position [6:0], value [38:7], zero pad [39]
   input  logic [iss_pkg::REQ_TDATA_WIDTH-1:0] req_tdata,
   // req_tuser: operation [2:0]
   input  logic [iss_pkg::OP_WIDTH-1:0]        req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // rsp_tdata: read_value [31:0], count [38:32], zero pad [39]
   input  logic [iss_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata,
   // rsp_tuser: status [1:0]
   input  logic [iss_pkg::STATUS_WIDTH-1:0]    rsp_tuser,
   output int                                  mismatches,
   output int                                  responses_owed,
   output int                                  list_length
);

   localparam int STORE_DEPTH = iss_pkg::DEPTH_DEFAULT;
   localparam int REPORT_LIMIT = 10;

   // One predicted response.
   typedef struct packed {
      logic [iss_pkg::DATA_WIDTH-1:0]  value;
      logic [iss_pkg::COUNT_WIDTH-1:0] count;
      iss_pkg::iss_status_type         status;
   } list_response_type;

   logic [iss_pkg::DATA_WIDTH-1:0] list_words [STORE_DEPTH];
   int unsigned                    list_size;
   list_response_type              owed_responses [$];
   int                             fail_total;
   int                             reported;

   // Applies one operation to the shadow list and returns the response it owes.
   function automatic list_response_type apply_list_op(
      iss_pkg::iss_op_type op, logic [iss_pkg::POS_WIDTH-1:0] pos,
      logic [iss_pkg::DATA_WIDTH-1:0] word);
      list_response_type res;
      int unsigned       idx;
      res.value  = '0;
      res.status = iss_pkg::ST_OK;
      idx        = {25'd0, pos};
      case (op)
         iss_pkg::OP_PUSH_FRONT, iss_pkg::OP_PUSH_BACK, iss_pkg::OP_INSERT: begin
            // A full list is flagged before the index is looked at.
            if (list_size >= STORE_DEPTH) begin
               res.status = iss_pkg::ST_FULL;
            end else if (op == iss_pkg::OP_INSERT && idx > list_size) begin
               res.status = iss_pkg::ST_RANGE;
            end else begin
               if (op == iss_pkg::OP_PUSH_FRONT) idx = 0;
               else if (op == iss_pkg::OP_PUSH_BACK) idx = list_size;
               for (int i = int'(list_size); i > idx; i--) list_words[i] = list_words[i-1];
               list_words[idx] = word;
               list_size++;
            end
         end
         iss_pkg::OP_REMOVE, iss_pkg::OP_POP_FRONT, iss_pkg::OP_POP_BACK,
         iss_pkg::OP_READ: begin
            // An empty list is flagged before the index is looked at.
            if (list_size == 0) begin
               res.status = iss_pkg::ST_EMPTY;
            end else begin
               if (op == iss_pkg::OP_POP_FRONT) idx = 0;
               else if (op == iss_pkg::OP_POP_BACK) idx = list_size - 1;
               if (idx >= list_size) begin
                  res.status = iss_pkg::ST_RANGE;
               end else begin
                  res.value = list_words[idx];
                  if (op != iss_pkg::OP_READ) begin
                     for (int i = int'(idx); i + 1 < list_size; i++) begin
                        list_words[i] = list_words[i+1];
                     end
                     list_size--;
                  end
               end
            end
         end
         default: begin
            list_size = 0;
         end
      endcase
      res.count = iss_pkg::COUNT_WIDTH'(list_size);
      return res;
   endfunction

   // Responses are retired before the request of the same edge is predicted.
   always @(posedge clock) begin
      list_response_type want;
      if (reset) begin
         owed_responses.delete();
         list_size  = 0;
         fail_total = 0;
         reported   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_responses.size() == 0) begin
               fail_total++;
               if (reported < REPORT_LIMIT) begin
                  reported++;
                  $display("%0t: response with nothing owed: value %h count %0d status %0d",
                           $time, rsp_tdata[31:0], rsp_tdata[38:32], rsp_tuser);
               end
            end else begin
               want = owed_responses.pop_front();
               if (want.value !== rsp_tdata[31:0] || want.count !== rsp_tdata[38:32] ||
                   want.status !== rsp_tuser) begin
                  fail_total++;
                  if (reported < REPORT_LIMIT) begin
                     reported++;
                     $display("%0t: mismatch value exp %h got %h, count exp %0d got %0d, %s",
                              $time, want.value, rsp_tdata[31:0], want.count,
                              rsp_tdata[38:32], $sformatf("status exp %0d got %0d",
                              want.status, rsp_tuser));
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            owed_responses.push_back(apply_list_op(iss_pkg::iss_op_type'(req_tuser),
                                                   req_tdata[6:0], req_tdata[38:7]));
         end
      end
      mismatches     <= fail_total;
      responses_owed <= owed_responses.size();
      list_length    <= int'(list_size);
   end

endmodule

// ===== dv/tb_indexed_sequence_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed sequence store testbench
// Drives a directed opening and then phases of random operations that fill,
// drain and churn the list, with random idle bursts on both channels, one
// long response stall and one full drain pause. A checker predicts and
// compares every response; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_indexed_sequence_store;

   localparam int RANDOM_ITEMS   = 1450;
   localparam int QUIET_TAIL     = 150;
   localparam int LONG_STALL     = 200;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 10;

   typedef enum {FILL_PHASE, DRAIN_PHASE, MIXED_PHASE} phase_kind_type;

   logic                                clock;
   logic                                reset;
   logic                                req_tvalid;
   logic                                req_tready;
   logic [iss_pkg::REQ_TDATA_WIDTH-1:0] req_tdata;
   logic [iss_pkg::OP_WIDTH-1:0]        req_tuser;
   logic                                rsp_tvalid;
   logic                                rsp_tready;
   logic [iss_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic [iss_pkg::STATUS_WIDTH-1:0]    rsp_tuser;

   int mismatches;
   int responses_owed;
   int list_length;
   int idle_pct;
   bit hold_responses;
   int quiet_cycles;

   indexed_sequence_store u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   iss_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatches     (mismatches),
      .responses_owed (responses_owed),
      .list_length    (list_length)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Offers one request, holds it until the transfer, then maybe idles.
   task automatic send_request(input iss_pkg::iss_op_type op,
                               input logic [iss_pkg::POS_WIDTH-1:0] pos,
                               input logic [iss_pkg::DATA_WIDTH-1:0] word);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, word, pos};
      do @(posedge clock); while (!req_tready);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
   endtask

   // Stops offering and waits until every owed response has arrived.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (responses_owed != 0) @(posedge clock);
   endtask

   // Draws one operation whose mix depends on the phase; most positions are
   // legal for the current length, some sit on or just past its end.
   task automatic draw_request(input phase_kind_type phase,
                               output iss_pkg::iss_op_type op,
                               output logic [iss_pkg::POS_WIDTH-1:0] pos,
                               output logic [iss_pkg::DATA_WIDTH-1:0] word);
      int weights [8];
      int pick;
      int n;
      case (phase)
         FILL_PHASE:  weights = '{25, 25, 30, 5, 3, 3, 9, 0};
         DRAIN_PHASE: weights = '{5, 5, 5, 30, 20, 20, 14, 1};
         default:     weights = '{12, 12, 16, 16, 10, 10, 20, 4};
      endcase
      pick = $urandom_range(0, 99);
      op   = iss_pkg::OP_CLEAR;
      for (int k = 0; k < 8; k++) begin
         if (pick < weights[k]) begin
            op = iss_pkg::iss_op_type'(k);
            break;
         end
         pick -= weights[k];
      end
      n    = list_length;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         if (op == iss_pkg::OP_INSERT) pos = iss_pkg::POS_WIDTH'($urandom_range(0, n));
         else pos = (n == 0) ? '0 : iss_pkg::POS_WIDTH'($urandom_range(0, n - 1));
      end else if (pick < 82) begin
         pos = iss_pkg::POS_WIDTH'(n);
      end else if (pick < 90) begin
         pos = iss_pkg::POS_WIDTH'(n + 1);
      end else begin
         pos = iss_pkg::POS_WIDTH'($urandom_range(0, 127));
      end
      if ($urandom_range(0, 99) < 85) begin
         word = $urandom;
      end else begin
         case ($urandom_range(0, 3))
            0:       word = 32'h7fff_ffff;
            1:       word = 32'h8000_0000;
            2:       word = 32'hffff_ffff;
            default: word = 32'h0000_0000;
         endcase
      end
   endtask

   // Response side: random stall bursts, one long hold when asked for.
   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_responses) begin
            hold_responses = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Ends the run when neither channel has moved a transfer for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Stimulus and verdict.
   initial begin
      phase_kind_type                 phase;
      int                             phase_left;
      iss_pkg::iss_op_type            op;
      logic [iss_pkg::POS_WIDTH-1:0]  pos;
      logic [iss_pkg::DATA_WIDTH-1:0] word;
      phase_left     = 0;
      phase          = MIXED_PHASE;
      idle_pct       = 20;
      hold_responses = 1'b0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= iss_pkg::OP_PUSH_FRONT;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Empty list: every take reports empty, even with a wild index.
      send_request(iss_pkg::OP_POP_FRONT, 7'd0, 32'd0);
      send_request(iss_pkg::OP_READ, 7'd0, 32'd0);
      send_request(iss_pkg::OP_REMOVE, 7'd127, 32'd0);
      send_request(iss_pkg::OP_POP_BACK, 7'd0, 32'd0);
      send_request(iss_pkg::OP_CLEAR, 7'd0, 32'd0);
      // Build a short list with extreme words; insert at the length appends.
      send_request(iss_pkg::OP_PUSH_FRONT, 7'd0, 32'h7fff_ffff);
      send_request(iss_pkg::OP_PUSH_BACK, 7'd0, 32'h8000_0000);
      send_request(iss_pkg::OP_INSERT, 7'd0, 32'h0000_0000);
      send_request(iss_pkg::OP_INSERT, 7'd3, 32'hffff_ffff);
      // Indexes past the end, mixed with in-range reads, removes and pops.
      send_request(iss_pkg::OP_INSERT, 7'd5, 32'h1234_5678);
      send_request(iss_pkg::OP_INSERT, 7'd127, 32'h1234_5678);
      send_request(iss_pkg::OP_READ, 7'd4, 32'd0);
      send_request(iss_pkg::OP_READ, 7'd127, 32'd0);
      send_request(iss_pkg::OP_READ, 7'd3, 32'd0);
      send_request(iss_pkg::OP_REMOVE, 7'd1, 32'd0);
      send_request(iss_pkg::OP_REMOVE, 7'd3, 32'd0);
      send_request(iss_pkg::OP_READ, 7'd0, 32'd0);
      send_request(iss_pkg::OP_POP_FRONT, 7'd0, 32'd0);
      send_request(iss_pkg::OP_POP_BACK, 7'd0, 32'd0);
      // Clear a non-empty list, then start again from an insert at zero.
      send_request(iss_pkg::OP_PUSH_BACK, 7'd0, 32'h5555_5555);
      send_request(iss_pkg::OP_CLEAR, 7'd64, 32'hffff_ffff);
      send_request(iss_pkg::OP_READ, 7'd0, 32'd0);
      send_request(iss_pkg::OP_INSERT, 7'd0, 32'h5555_5555);
      send_request(iss_pkg::OP_PUSH_BACK, 7'd0, 32'haaaa_aaaa);

      // Random phases that push the list to full, drain it, or churn it.
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (phase_left == 0) begin
            phase      = phase_kind_type'($urandom_range(0, 2));
            phase_left = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 15;
               default: idle_pct = 40;
            endcase
         end
         if (k >= RANDOM_ITEMS - QUIET_TAIL) idle_pct = 0;
         if (k == 400) hold_responses = 1'b1;
         if (k == 800) wait_for_drain();
         draw_request(phase, op, pos, word);
         send_request(op, pos, word);
         phase_left--;
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && responses_owed == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
